### rtl/core/owmd_pkg.sv
package owmd_pkg;

  localparam int IN_W    = 16;
  localparam int LIM_W   = 15;
  localparam int OUT_W   = 18;
  localparam int MAG_W   = 17;
  localparam int LANES   = 3;

  // Product of the forward command and the Q0.16 coefficient
  localparam int COEF_W  = 17;
  localparam int PROD_W  = IN_W + COEF_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int COEF_SHIFT = 16;
  localparam logic [COEF_W-1:0] COEF_COS30 = COEF_W'(56756);
  localparam logic [SUM_W-1:0]  RND_HALF   = SUM_W'(1) << (COEF_SHIFT - 1);

  // Scaling divide: |speed| * limit / largest, quotient never exceeds the limit
  localparam int NUM_W   = MAG_W + LIM_W;
  localparam int Q_W     = LIM_W;

  // Pipeline layout: six front stages, one stage per quotient bit, output register
  localparam int DIV_FIRST = 6;
  localparam int OUT_STAGE = DIV_FIRST + Q_W;
  localparam int NSTAGE    = OUT_STAGE + 1;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [Q_W-1:0]   acc;
  } div_lane_t;

  typedef struct packed {
    logic                        scale;
    logic [LANES-1:0]            neg;
    logic [MAG_W-1:0]            divisor;
    logic [LANES-1:0][OUT_W-1:0] w;
  } side_t;

  // Round a value with COEF_SHIFT extra fraction bits to nearest, ties away from zero
  function automatic logic [OUT_W-1:0] round_back(input logic signed [SUM_W-1:0] w);
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] r;
    a = w[SUM_W-1] ? SUM_W'(-w) : SUM_W'(w);
    r = (a + RND_HALF) >> COEF_SHIFT;
    return w[SUM_W-1] ? OUT_W'(-r[OUT_W-1:0]) : r[OUT_W-1:0];
  endfunction

endpackage

### rtl/core/owmd_div_step.sv
module owmd_div_step import owmd_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [MAG_W-1:0]       divisor,
  input  div_lane_t [LANES-1:0]  lane_in,
  output div_lane_t [LANES-1:0]  lane_out
);

  div_lane_t [LANES-1:0]    lane_next;
  logic [LANES-1:0][MAG_W:0] trial;

  // One restoring step per lane: bring down the next numerator bit, subtract if it fits
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      trial[i] = {lane_in[i].rem, lane_in[i].acc[Q_W-1]};
      if (trial[i] >= {1'b0, divisor}) begin
        lane_next[i].rem = MAG_W'(trial[i] - {1'b0, divisor});
        lane_next[i].acc = {lane_in[i].acc[Q_W-2:0], 1'b1};
      end else begin
        lane_next[i].rem = trial[i][MAG_W-1:0];
        lane_next[i].acc = {lane_in[i].acc[Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule

### rtl/core/omni_wheel_mixer_desaturate.sv
// Channel   Direction  Handshake          Payload
// command   in         in_valid/in_stall  right_cmd, forward_cmd, yaw_cmd, output_limit
// wheels    out        out_valid/out_stall wheel_one_speed, wheel_two_speed,
//                                          wheel_three_speed, was_limited
//
// One command per cycle, from command transfer to wheel result, while out_stall is low.
// Depth is set by the scaling divide, which resolves one quotient bit per stage.
// Each stage holds its own valid bit and loads whenever it is empty or the next one loads,
// so bubbles close up under out_stall and commands keep entering while a result waits.
// rst clears all valid bits synchronously; data registers are not reset.
module omni_wheel_mixer_desaturate import owmd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  right_cmd,
  input  logic signed [IN_W-1:0]  forward_cmd,
  input  logic signed [IN_W-1:0]  yaw_cmd,
  input  logic [LIM_W-1:0]        output_limit,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] wheel_one_speed,
  output logic signed [OUT_W-1:0] wheel_two_speed,
  output logic signed [OUT_W-1:0] wheel_three_speed,
  output logic                    was_limited
);

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] adv;

  // stage 1: wheel one and the coefficient product
  logic signed [OUT_W-1:0]  s0_p1;
  logic signed [PROD_W-1:0] prod_p1;
  logic signed [IN_W-1:0]   yaw_p1;
  logic signed [IN_W-1:0]   right_p1;
  logic [LIM_W-1:0]         lim_p1;

  // stage 2: exact sums
  logic signed [OUT_W-1:0]  s0_p2;
  logic signed [SUM_W-1:0]  t1_p2;
  logic signed [SUM_W-1:0]  t2_p2;
  logic [LIM_W-1:0]         lim_p2;
  logic signed [SUM_W-1:0]  base_sum;

  // stage 3: rounded wheel speeds
  logic [LANES-1:0][OUT_W-1:0] w_p3;
  logic [LIM_W-1:0]            lim_p3;

  // stage 4: magnitudes
  logic [LANES-1:0][OUT_W-1:0] w_p4;
  logic [LANES-1:0][MAG_W-1:0] mag_p4;
  logic [LANES-1:0]            neg_p4;
  logic [LIM_W-1:0]            lim_p4;

  // stage 5: largest magnitude and scale decision
  logic [LANES-1:0][OUT_W-1:0] w_p5;
  logic [LANES-1:0][MAG_W-1:0] mag_p5;
  logic [LANES-1:0]            neg_p5;
  logic [LIM_W-1:0]            lim_p5;
  logic [MAG_W-1:0]            big_p5;
  logic                        scale_p5;
  logic [MAG_W-1:0]            big01;
  logic [MAG_W-1:0]            big_next;

  // stage 6 onward: divide lanes and side data
  div_lane_t [LANES-1:0] lane_init;
  logic [LANES-1:0][NUM_W-1:0] num;
  div_lane_t [LANES-1:0] lane [Q_W+1];
  side_t                 side [Q_W+1];

  logic [LANES-1:0][OUT_W-1:0] res_next;

  // Handshake chain: a stage loads when empty or when the stage after it loads
  always_comb begin
    adv[NSTAGE-1] = !vld[NSTAGE-1] || !out_stall;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_p1    <= OUT_W'(yaw_cmd) - OUT_W'(right_cmd);
      prod_p1  <= PROD_W'(forward_cmd) * PROD_W'($signed({1'b0, COEF_COS30}));
      yaw_p1   <= yaw_cmd;
      right_p1 <= right_cmd;
      lim_p1   <= output_limit;
    end
  end

  assign base_sum = (SUM_W'(yaw_p1) <<< COEF_SHIFT) + (SUM_W'(right_p1) <<< (COEF_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s0_p2  <= s0_p1;
      t1_p2  <= base_sum - SUM_W'(prod_p1);
      t2_p2  <= base_sum + SUM_W'(prod_p1);
      lim_p2 <= lim_p1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      w_p3[0] <= s0_p2;
      w_p3[1] <= round_back(t1_p2);
      w_p3[2] <= round_back(t2_p2);
      lim_p3  <= lim_p2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < LANES; i++) begin
        neg_p4[i] <= w_p3[i][OUT_W-1];
        mag_p4[i] <= w_p3[i][OUT_W-1] ? MAG_W'(-w_p3[i]) : w_p3[i][MAG_W-1:0];
      end
      w_p4   <= w_p3;
      lim_p4 <= lim_p3;
    end
  end

  assign big01    = (mag_p4[1] > mag_p4[0]) ? mag_p4[1] : mag_p4[0];
  assign big_next = (mag_p4[2] > big01) ? mag_p4[2] : big01;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      big_p5   <= big_next;
      scale_p5 <= (lim_p4 != '0) && (big_next > MAG_W'(lim_p4));
      w_p5     <= w_p4;
      mag_p5   <= mag_p4;
      neg_p5   <= neg_p4;
      lim_p5   <= lim_p4;
    end
  end

  // Numerator split: high part seeds the remainder, low part feeds the quotient steps
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      num[i] = NUM_W'(mag_p5[i]) * NUM_W'(lim_p5);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int i = 0; i < LANES; i++) begin
        lane_init[i].rem <= num[i][NUM_W-1:Q_W];
        lane_init[i].acc <= num[i][Q_W-1:0];
      end
      side[0].scale   <= scale_p5;
      side[0].neg     <= neg_p5;
      side[0].divisor <= big_p5;
      side[0].w       <= w_p5;
    end
  end

  assign lane[0] = lane_init;

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    owmd_div_step u_step (
      .clk      (clk),
      .en       (adv[DIV_FIRST+j]),
      .divisor  (side[j].divisor),
      .lane_in  (lane[j]),
      .lane_out (lane[j+1])
    );

    always_ff @(posedge clk) begin
      if (adv[DIV_FIRST+j]) begin
        side[j+1] <= side[j];
      end
    end
  end

  // Restore sign of the scaled magnitude, or pass the unscaled speed
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (side[Q_W].scale) begin
        res_next[i] = side[Q_W].neg[i] ? OUT_W'(-OUT_W'(lane[Q_W][i].acc))
                                        : OUT_W'(lane[Q_W][i].acc);
      end else begin
        res_next[i] = side[Q_W].w[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[OUT_STAGE]) begin
      wheel_one_speed   <= res_next[0];
      wheel_two_speed   <= res_next[1];
      wheel_three_speed <= res_next[2];
      was_limited       <= side[Q_W].scale;
    end
  end

endmodule
